[rtl/hfcp_pkg.sv]
// ----------------------------------------------------------------------------
// hfcp_pkg
// shared types and codes of the hole-fill compaction planner
// ----------------------------------------------------------------------------
`default_nettype none

package hfcp_pkg;

  localparam int SLOT_W = 12;  // slot index width
  localparam int CNT_W  = 13;  // count width
  localparam int FP_W   = 14;  // fill pointer, two's complement

  // request codes
  localparam logic [1:0] ACT_SET   = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_HOLE  = 2'd2;

  // result codes
  localparam logic [1:0] ST_ACK    = 2'd0;
  localparam logic [1:0] ST_MOVE   = 2'd1;
  localparam logic [1:0] ST_NOMOVE = 2'd2;
  localparam logic [1:0] ST_UNDER  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START_LIVE,
    S_START_FP,
    S_HOLE_CMP,
    S_WALK
  } hfcp_state_t;

  // result of the shared subtract unit
  typedef struct packed {
    logic            borrow;
    logic [FP_W-1:0] diff;
  } hfcp_sub_res_t;

endpackage

`default_nettype wire

[rtl/hole_fill_compaction_planner.sv]
// ----------------------------------------------------------------------------
// hole_fill_compaction_planner
// plans swap-from-end compaction of a slot array, at most one move per hole request
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low; its single
// result shows on the out_ ports for exactly one cycle, marked by out_valid,
// and the receiver cannot stall it. After reset the dead bitmap is swept to
// zero, one slot a cycle, and busy stays high through the sweep, so no request
// is taken before it ends. A set request gives its result in the cycle after
// acceptance and the block can take a request again in that same cycle. A start
// request forms the live count, then the fill pointer. A hole request ends at
// the compare when no move is needed or the fill pointer is already exhausted;
// otherwise the walk steps past each dead slot the fill pointer skips until a
// live candidate issues a move or the walk runs below slot zero. The walk
// tests one bitmap slot per cycle through the single bitmap read port, and
// one shared subtractor serves the live count, compare and pointer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module hole_fill_compaction_planner #(
  parameter int SLOTS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [11:0] in_slot_index,
  input  wire logic        in_dead_flag,
  input  wire logic [12:0] in_particle_total,
  input  wire logic [12:0] in_deleted_total,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [11:0]      out_move_source,
  output logic [11:0]      out_move_target,
  output logic [12:0]      out_live_after
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam int FW = hfcp_pkg::FP_W;
  localparam int CW = hfcp_pkg::CNT_W;
  localparam int SW = hfcp_pkg::SLOT_W;

  // a pointer value addresses a real bitmap slot
  function automatic logic fp_in_range(input logic [FW-1:0] p);
    return !p[FW-1] && ({{(32-FW+1){1'b0}}, p[FW-2:0]} < 32'(SLOTS));
  endfunction

  hfcp_pkg::hfcp_state_t state_r, state_nxt;

  logic [FW-1:0] fp_r, fp_nxt;          // fill pointer, signed
  logic [CW-1:0] live_r, live_nxt;      // live count
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt;      // latched request fields
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] deleted_r, deleted_nxt;
  logic          rd_ok_r, rd_ok_nxt;    // read address was inside the bitmap

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [SW-1:0] out_src_r, out_src_nxt;
  logic [SW-1:0] out_dst_r, out_dst_nxt;
  logic [CW-1:0] out_live_r, out_live_nxt;

  // shared subtractor
  logic [FW-1:0]           sub_a, sub_b;
  hfcp_pkg::hfcp_sub_res_t sub_res;

  // bitmap ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [FW-1:0] rd_ptr;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic accept;
  logic slot_ok;     // latched hole slot inside the bitmap
  logic in_slot_ok;  // incoming set slot inside the bitmap
  logic cand_dead;   // current walk candidate is dead

  hfcp_sub_unit u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  hfcp_dead_ram #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign busy       = (state_r != hfcp_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign slot_ok    = ({20'd0, slot_r} < 32'(SLOTS));
  assign in_slot_ok = ({20'd0, in_slot_index} < 32'(SLOTS));
  assign cand_dead  = rd_ok_r && ram_rdata;

  // walk reads one step ahead: the next candidate is fp - 1
  assign rd_ptr    = (state_r == hfcp_pkg::S_WALK) ? sub_res.diff : fp_r;
  assign ram_raddr = AW'(rd_ptr[FW-2:0]);

  // operand select for the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      hfcp_pkg::S_START_LIVE: begin
        sub_a = {1'b0, total_r};
        sub_b = {1'b0, deleted_r};
      end
      hfcp_pkg::S_START_FP: begin
        sub_a = {1'b0, total_r};
        sub_b = FW'(1);
      end
      hfcp_pkg::S_HOLE_CMP: begin
        sub_a = {2'b00, slot_r};
        sub_b = {1'b0, live_r};
      end
      hfcp_pkg::S_WALK: begin
        sub_a = fp_r;
        sub_b = FW'(1);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hfcp_pkg::S_CLEAR;
      fp_r        <= '0;
      live_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      live_r      <= live_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    total_r      <= total_nxt;
    deleted_r    <= deleted_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_dst_r    <= out_dst_nxt;
    out_live_r   <= out_live_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    fp_nxt         = fp_r;
    live_nxt       = live_r;
    clr_cnt_nxt    = clr_cnt_r;
    slot_nxt       = slot_r;
    total_nxt      = total_r;
    deleted_nxt    = deleted_r;
    rd_ok_nxt      = fp_in_range(rd_ptr);
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;
    out_dst_nxt    = out_dst_r;
    out_live_nxt   = out_live_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(slot_r);
    ram_wdata      = 1'b0;

    case (state_r)
      // sweep the bitmap to all live after reset
      hfcp_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST) begin
          state_nxt = hfcp_pkg::S_IDLE;
        end
      end

      hfcp_pkg::S_IDLE: begin
        if (accept) begin
          slot_nxt    = in_slot_index;
          total_nxt   = in_particle_total;
          deleted_nxt = in_deleted_total;
          case (in_action)
            hfcp_pkg::ACT_START: state_nxt = hfcp_pkg::S_START_LIVE;
            hfcp_pkg::ACT_HOLE:  state_nxt = hfcp_pkg::S_HOLE_CMP;
            default: begin
              // set request, or unused code: acknowledge at once
              if (in_action == hfcp_pkg::ACT_SET && in_slot_ok) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(in_slot_index);
                ram_wdata = in_dead_flag;
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = hfcp_pkg::ST_ACK;
              out_src_nxt    = '0;
              out_dst_nxt    = '0;
              out_live_nxt   = live_r;
            end
          endcase
        end
      end

      // live = total - deleted, saturating at zero
      hfcp_pkg::S_START_LIVE: begin
        live_nxt  = sub_res.borrow ? '0 : sub_res.diff[CW-1:0];
        state_nxt = hfcp_pkg::S_START_FP;
      end

      // fill pointer = total - 1, a zero total gives minus one
      hfcp_pkg::S_START_FP: begin
        fp_nxt         = sub_res.diff;
        out_valid_nxt  = 1'b1;
        out_status_nxt = hfcp_pkg::ST_ACK;
        out_src_nxt    = '0;
        out_dst_nxt    = '0;
        out_live_nxt   = live_r;
        state_nxt      = hfcp_pkg::S_IDLE;
      end

      // hole below live count needs a move; bitmap read of fp issued here
      hfcp_pkg::S_HOLE_CMP: begin
        out_src_nxt  = '0;
        out_dst_nxt  = '0;
        out_live_nxt = live_r;
        if (!sub_res.borrow) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hfcp_pkg::ST_NOMOVE;
          state_nxt      = hfcp_pkg::S_IDLE;
        end else if (fp_r[FW-1]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hfcp_pkg::ST_UNDER;
          fp_nxt         = '1;
          state_nxt      = hfcp_pkg::S_IDLE;
        end else begin
          state_nxt = hfcp_pkg::S_WALK;
        end
      end

      // candidate is fp; its flag arrived from the read issued last cycle
      hfcp_pkg::S_WALK: begin
        fp_nxt       = sub_res.diff;
        out_live_nxt = live_r;
        if (!cand_dead) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hfcp_pkg::ST_MOVE;
          out_src_nxt    = fp_r[SW-1:0];
          out_dst_nxt    = slot_r;
          ram_we         = slot_ok;
          ram_waddr      = AW'(slot_r);
          ram_wdata      = 1'b0;
          state_nxt      = hfcp_pkg::S_IDLE;
        end else if (sub_res.diff[FW-1]) begin
          // walked below slot zero
          out_valid_nxt  = 1'b1;
          out_status_nxt = hfcp_pkg::ST_UNDER;
          out_src_nxt    = '0;
          out_dst_nxt    = '0;
          state_nxt      = hfcp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = hfcp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_move_source = out_src_r;
  assign out_move_target = out_dst_r;
  assign out_live_after  = out_live_r;

  // an underflow result always leaves the pointer parked at minus one
  a_under_parks_fp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == hfcp_pkg::ST_UNDER) |-> (fp_r == '1))
    else $error("underflow reported with fill pointer not at minus one");

  // every walk cycle consumes exactly one slot of the fill pointer
  a_walk_steps_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hfcp_pkg::S_WALK) |=> (fp_r == $past(fp_r) - FW'(1)))
    else $error("fill pointer did not step down by one in walk");

  // no result can follow a clearing sweep cycle
  a_no_result_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hfcp_pkg::S_CLEAR) |=> !out_valid_r)
    else $error("result issued during bitmap clear");

  // a move never targets a hole at or above the live count
  a_move_below_live: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == hfcp_pkg::ST_MOVE)
      |-> ({1'b0, out_dst_r} < out_live_r))
    else $error("move issued into a hole beyond the live count");

endmodule

`default_nettype wire

[rtl/hfcp_sub_unit.sv]
// ----------------------------------------------------------------------------
// hfcp_sub_unit
// shared subtract and compare unit: a - b with borrow out
// ----------------------------------------------------------------------------
`default_nettype none

module hfcp_sub_unit (
  input  wire logic [hfcp_pkg::FP_W-1:0] a,
  input  wire logic [hfcp_pkg::FP_W-1:0] b,
  output hfcp_pkg::hfcp_sub_res_t        res
);

  logic [hfcp_pkg::FP_W:0] full;

  assign full       = {1'b0, a} - {1'b0, b};
  assign res.borrow = full[hfcp_pkg::FP_W];
  assign res.diff   = full[hfcp_pkg::FP_W-1:0];

endmodule

`default_nettype wire

[rtl/hfcp_dead_ram.sv]
// ----------------------------------------------------------------------------
// hfcp_dead_ram
// dead flag bitmap, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hfcp_dead_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata_r
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

[bench/hfcp_plan_checker.sv]
// ----------------------------------------------------------------------------
// hfcp_plan_checker
// watches the request and result ports of the compaction planner, keeps its
// own copy of the dead bitmap, fill pointer and live count, and compares
// every result field with the planned move of the oldest open request
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hfcp_plan_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [11:0] in_slot_index,
  input  logic        in_dead_flag,
  input  logic [12:0] in_particle_total,
  input  logic [12:0] in_deleted_total,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [11:0] out_move_source,
  input  logic [11:0] out_move_target,
  input  logic [12:0] out_live_after,
  output int          errors,
  output int          pending,
  output int          request_count,
  output int          move_count,
  output int          skip_count,
  output int          under_count
);

  localparam int MAP_DEPTH = 4096;
  localparam int PRINT_CAP = 30;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] source;
    logic [11:0] target;
    logic [12:0] live;
  } move_plan_t;

  bit          dead_bits [0:MAP_DEPTH-1];
  int          fill_ptr;
  logic [12:0] live_cnt;
  move_plan_t  plan_queue [$];

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // slots past the bitmap read as live
  function automatic bit slot_is_dead(input int s);
    if (s < 0 || s >= MAP_DEPTH) return 1'b0;
    return dead_bits[s];
  endfunction

  function automatic move_plan_t plan_request(input logic [1:0] act,
                                              input logic [11:0] slot,
                                              input logic flag,
                                              input logic [12:0] total,
                                              input logic [12:0] deleted);
    move_plan_t p;
    int take;
    p = '0;
    p.status = hfcp_pkg::ST_ACK;
    case (act)
      hfcp_pkg::ACT_SET: dead_bits[slot] = flag;
      hfcp_pkg::ACT_START: begin
        fill_ptr = int'(total) - 1;
        live_cnt = (deleted > total) ? 13'd0 : total - deleted;
      end
      hfcp_pkg::ACT_HOLE: begin
        if ({1'b0, slot} >= live_cnt) begin
          p.status = hfcp_pkg::ST_NOMOVE;
        end else begin
          take = fill_ptr;
          if (fill_ptr >= 0) fill_ptr--;
          while (take >= 0 && slot_is_dead(take)) begin
            take = fill_ptr;
            if (fill_ptr >= 0) fill_ptr--;
          end
          if (take < 0) begin
            p.status = hfcp_pkg::ST_UNDER;
            fill_ptr = -1;
          end else begin
            p.status = hfcp_pkg::ST_MOVE;
            p.source = take[11:0];
            p.target = slot;
            dead_bits[slot] = slot_is_dead(take);
          end
        end
      end
      default: ;
    endcase
    p.live = live_cnt;
    return p;
  endfunction

  always @(posedge clk) begin : watch_ports
    move_plan_t want;
    if (!rst_n) begin
      foreach (dead_bits[i]) dead_bits[i] = 1'b0;
      fill_ptr = 0;
      live_cnt = '0;
      plan_queue.delete();
    end else begin
      if (out_valid) begin
        if (plan_queue.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = plan_queue.pop_front();
          compare_field("status", 13'(want.status), 13'(out_status));
          compare_field("move_source", 13'(want.source), 13'(out_move_source));
          compare_field("move_target", 13'(want.target), 13'(out_move_target));
          compare_field("live_after", want.live, out_live_after);
          case (want.status)
            hfcp_pkg::ST_MOVE:   move_count++;
            hfcp_pkg::ST_NOMOVE: skip_count++;
            hfcp_pkg::ST_UNDER:  under_count++;
            default: ;
          endcase
        end
      end
      if (start && !busy) begin
        plan_queue.push_back(plan_request(in_action, in_slot_index, in_dead_flag,
                                          in_particle_total, in_deleted_total));
        request_count++;
      end
    end
    pending = plan_queue.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives the compaction planner with directed corner requests and then
// random mark / start / fill sequences; a checker beside the block predicts
// each planned move, and this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;  // code the block ignores
  localparam int ITEM_TARGET    = 1200;
  localparam int WATCHDOG_LIMIT = 20000;     // covers the bitmap sweep and long walks
  localparam int SETTLE_CYCLES  = 10;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [11:0] in_slot_index;
  logic        in_dead_flag;
  logic [12:0] in_particle_total;
  logic [12:0] in_deleted_total;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [11:0] out_move_source;
  logic [11:0] out_move_target;
  logic [12:0] out_live_after;

  int check_errors;
  int outstanding;
  int request_count;
  int move_count;
  int skip_count;
  int under_count;

  int sent;
  int stall_cycles;
  bit gaps_on;

  hole_fill_compaction_planner #(.SLOTS(4096)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .in_dead_flag      (in_dead_flag),
    .in_particle_total (in_particle_total),
    .in_deleted_total  (in_deleted_total),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_move_source   (out_move_source),
    .out_move_target   (out_move_target),
    .out_live_after    (out_live_after)
  );

  hfcp_plan_checker plan_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .in_dead_flag      (in_dead_flag),
    .in_particle_total (in_particle_total),
    .in_deleted_total  (in_deleted_total),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_move_source   (out_move_source),
    .out_move_target   (out_move_target),
    .out_live_after    (out_live_after),
    .errors            (check_errors),
    .pending           (outstanding),
    .request_count     (request_count),
    .move_count        (move_count),
    .skip_count        (skip_count),
    .under_count       (under_count)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // watchdog: any accepted request or result clears it
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $time, stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request, entered at a falling edge; returns at the falling edge after
  // acceptance with start still high so back-to-back requests need no toggle
  task automatic send_request(input logic [1:0] act, input logic [11:0] slot,
                              input logic flag, input logic [12:0] total,
                              input logic [12:0] deleted);
    if (gaps_on && $urandom_range(0, 99) < 28) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start             = 1'b1;
    in_action         = act;
    in_slot_index     = slot;
    in_dead_flag      = flag;
    in_particle_total = total;
    in_deleted_total  = deleted;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  // fields a request does not use still get random values
  task automatic set_flag(input logic [11:0] slot, input logic flag);
    send_request(hfcp_pkg::ACT_SET, slot, flag, 13'($urandom_range(0, 4096)),
                 13'($urandom_range(0, 4096)));
  endtask

  task automatic start_plan(input logic [12:0] total, input logic [12:0] deleted);
    send_request(hfcp_pkg::ACT_START, 12'($urandom_range(0, 4095)),
                 1'($urandom_range(0, 1)), total, deleted);
  endtask

  task automatic fill_hole(input logic [11:0] slot);
    send_request(hfcp_pkg::ACT_HOLE, slot, 1'($urandom_range(0, 1)),
                 13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)));
  endtask

  // hold requests back until every planned move has come out
  task automatic drain_outstanding();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int span;
    int kills;
    int victim;
    int gone;
    int pick;
    bit pressured;
    int hole_list [$];

    clk               = 1'b0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_action         = hfcp_pkg::ACT_SET;
    in_slot_index     = '0;
    in_dead_flag      = 1'b0;
    in_particle_total = '0;
    in_deleted_total  = '0;
    sent              = 0;
    gaps_on           = 1'b1;
    pressured         = 1'b0;

    // reset held low, then released at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    set_flag(12'd0, 1'b1);
    set_flag(12'd4095, 1'b1);
    set_flag(12'd4095, 1'b0);
    send_request(ACT_UNUSED, 12'($urandom_range(0, 4095)), 1'b1, 13'd4096, 13'd4096);
    fill_hole(12'd0);                // nothing started, live count zero
    start_plan(13'd0, 13'd0);        // empty array, pointer starts below zero
    fill_hole(12'd4095);
    start_plan(13'd10, 13'd20);      // more deleted than total, live saturates
    fill_hole(12'd3);
    start_plan(13'd4096, 13'd0);     // full array
    set_flag(12'd4095, 1'b1);
    set_flag(12'd4094, 1'b1);
    fill_hole(12'd5);                // walk skips the two dead top slots
    fill_hole(12'd4095);             // hole is itself a dead top slot
    start_plan(13'd8191, 13'd0);     // pointer starts past the bitmap
    fill_hole(12'd7);                // source past the bitmap reads live
    start_plan(13'd4096, 13'd4096);  // everything deleted
    fill_hole(12'd4095);
    set_flag(12'd1, 1'b1);
    set_flag(12'd2, 1'b1);
    start_plan(13'd3, 13'd1);        // only dead slots left to walk
    fill_hole(12'd0);                // walk runs below slot zero
    fill_hole(12'd1);                // pointer already exhausted
    set_flag(12'd0, 1'b0);
    start_plan(13'd1, 13'd0);
    fill_hole(12'd0);                // slot moves onto itself
    drain_outstanding();

    // random part: mostly well-formed mark / start / fill sequences
    while (sent < ITEM_TARGET) begin
      gaps_on = !(sent >= 500 && sent < 800);  // one long stretch at full rate
      if (!pressured && sent >= 300) begin
        drain_outstanding();
        pressured = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // mostly small arrays, now and then up to the full bitmap
        span  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4096)
                                              : $urandom_range(1, 48);
        kills = $urandom_range(0, (span < 12) ? span : 12);
        hole_list.delete();
        if ($urandom_range(0, 3) == 0)
          set_flag(12'($urandom_range(0, span - 1)), 1'b0);  // revive a stale slot
        repeat (kills) begin
          // half the victims near the top so the walk has dead slots to skip
          if ($urandom_range(0, 1))
            victim = $urandom_range(0, span - 1);
          else
            victim = span - 1 - $urandom_range(0, (span < 16) ? span - 1 : 15);
          set_flag(12'(victim), 1'b1);
          hole_list.push_back(victim);
        end
        // a wrong deleted count now and then drives the pointer to underflow
        gone = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : kills;
        start_plan(13'(span), 13'(gone));
        hole_list.sort();
        foreach (hole_list[i]) fill_hole(12'(hole_list[i]));
        if ($urandom_range(0, 2) == 0)
          fill_hole(12'($urandom_range(0, span - 1)));
      end else if (pick < 90) begin
        // noise: any code, any fields
        send_request(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                     1'($urandom_range(0, 1)), 13'($urandom_range(0, 4096)),
                     13'($urandom_range(0, 4096)));
      end else if (pick < 95) begin
        fill_hole(12'($urandom_range(0, 4095)));  // hole out of sequence
      end else begin
        start_plan(13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)));
      end
    end

    drain_outstanding();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests after reset and the bitmap sweep", request_count);
    $display("moves %0d, holes needing no move %0d, pointer underflows %0d",
             move_count, skip_count, under_count);
    if (check_errors == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
